// File: rtl/fdma_pkg.sv
// Package for the fall detector: widths, window length, codes and the
// command bundle passed from the controller to the datapath.
// No dependencies; every other file of the block uses it.
package fdma_pkg;

    localparam int ACCEL_W     = 16;
    localparam int MAG_W       = 16;
    localparam int THRESH_W    = 16;
    localparam int STATE_W     = 2;
    localparam int WINDOW_LEN  = 16;
    localparam int WIN_LOG2    = $clog2(WINDOW_LEN);
    localparam int PTR_W       = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;
    localparam int SUM_W       = MAG_W + WIN_LOG2;
    localparam int SQ_W        = 2 * ACCEL_W;
    localparam int REM_W       = MAG_W + 1;
    localparam int ROOT_STEPS  = SQ_W / 2;
    localparam int SQ_STEPS    = 4;
    localparam int CNT_W       = $clog2(ROOT_STEPS);
    localparam int CFG_INDEX_W = 1;

    localparam logic [STATE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [STATE_W-1:0] MODE_PRE_FALL = 2'd1;
    localparam logic [STATE_W-1:0] MODE_FALL     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       acc_en;
        logic [1:0] axis_sel;
        logic       root_init;
        logic       root_step;
        logic       update;
        logic       finish;
    } fdma_cmd_t;

endpackage

// File: rtl/fdma_sample_if.sv
// Request channel carrying one three-axis acceleration sample.
// Depends on fdma_pkg for the field widths.
interface fdma_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [fdma_pkg::ACCEL_W-1:0] accel_x;
    logic signed [fdma_pkg::ACCEL_W-1:0] accel_y;
    logic signed [fdma_pkg::ACCEL_W-1:0] accel_z;
    logic                                interval_elapsed;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output interval_elapsed, input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  input interval_elapsed, output ready);
endinterface

// File: rtl/fdma_result_if.sv
// Request channel carrying the detector state and the moving average.
// Depends on fdma_pkg for the field widths.
interface fdma_result_if;
    logic                          valid;
    logic                          ready;
    logic [fdma_pkg::STATE_W-1:0]  detector_state;
    logic [fdma_pkg::MAG_W-1:0]    average_magnitude;

    modport source (output valid, output detector_state, output average_magnitude,
                    input ready);
    modport sink (input valid, input detector_state, input average_magnitude,
                  output ready);
endinterface

// File: rtl/fdma_ctrl.sv
// Controller for the fall detector: sequences squaring, square root,
// window update and decision, and owns the request handshakes. Uses fdma_pkg.
module fdma_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output fdma_pkg::fdma_cmd_t cmd
);
    import fdma_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_RINIT = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(SQ_STEPS - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.axis_sel = cnt_reg[1:0];
                cmd.mul_en   = (cnt_reg != SQ_LAST);
                cmd.acc_en   = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT:
            begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/fdma_datapath.sv
// Datapath of the fall detector: squarer, bit-serial square root, magnitude
// ring with running sum, threshold registers and the detector state.
// Uses fdma_pkg; driven by fdma_ctrl commands.
module fdma_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fdma_pkg::fdma_cmd_t                 cmd,
    input  logic signed [fdma_pkg::ACCEL_W-1:0] accel_x,
    input  logic signed [fdma_pkg::ACCEL_W-1:0] accel_y,
    input  logic signed [fdma_pkg::ACCEL_W-1:0] accel_z,
    input  logic                                interval_elapsed,
    input  logic                                cfg_write_en,
    input  logic [fdma_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fdma_pkg::THRESH_W-1:0]       cfg_data,
    output logic [fdma_pkg::STATE_W-1:0]        detector_state,
    output logic [fdma_pkg::MAG_W-1:0]          average_magnitude
);
    import fdma_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

    logic signed [ACCEL_W-1:0] ax_reg, ay_reg, az_reg;
    logic                      elapsed_reg;
    logic signed [ACCEL_W-1:0] operand;
    logic signed [SQ_W-1:0]    product;
    logic [SQ_W-1:0]           product_reg;
    logic [SQ_W-1:0]           acc_reg;
    logic [SQ_W-1:0]           val_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [MAG_W-1:0]          root_reg;
    logic [REM_W+1:0]          rem_shift;
    logic [REM_W+1:0]          trial;
    logic [REM_W+1:0]          rem_diff;

    logic [MAG_W-1:0]          ring_reg [WINDOW_LEN];
    logic [PTR_W-1:0]          ptr_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic [STATE_W-1:0]        mode_reg;
    logic [STATE_W-1:0]        mode_next;
    logic [THRESH_W-1:0]       low_thr_reg;
    logic [THRESH_W-1:0]       high_thr_reg;
    logic [MAG_W-1:0]          avg;
    logic [STATE_W-1:0]        out_state_reg;
    logic [MAG_W-1:0]          out_avg_reg;

    always_comb
    begin
        case (cmd.axis_sel)
            AXIS_X:  operand = ax_reg;
            AXIS_Y:  operand = ay_reg;
            AXIS_Z:  operand = az_reg;
            default: operand = az_reg;
        endcase
    end

    assign product   = operand * operand;
    assign rem_shift = {rem_reg, val_reg[SQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;

    assign sum_next = sum_reg - SUM_W'(ring_reg[ptr_reg]) + SUM_W'(root_reg);
    assign avg      = MAG_W'(sum_reg >> WIN_LOG2);

    // The rules apply in order, so one sample may pass through several states.
    always_comb
    begin
        logic [STATE_W-1:0] m;
        m = mode_reg;
        if (m == MODE_IDLE && avg < low_thr_reg)
        begin
            m = MODE_PRE_FALL;
        end
        if (m == MODE_PRE_FALL)
        begin
            if (avg > high_thr_reg)
            begin
                m = MODE_FALL;
            end
            else if (elapsed_reg)
            begin
                m = MODE_IDLE;
            end
        end
        if (m == MODE_FALL && elapsed_reg)
        begin
            m = MODE_IDLE;
        end
        mode_next = m;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg      <= accel_x;
            ay_reg      <= accel_y;
            az_reg      <= accel_z;
            elapsed_reg <= interval_elapsed;
            acc_reg     <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + product_reg;
        end
        if (cmd.mul_en)
        begin
            product_reg <= product;
        end
        if (cmd.root_init)
        begin
            val_reg  <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            val_reg <= {val_reg[SQ_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_diff[REM_W-1:0];
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[REM_W-1:0];
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            out_state_reg <= mode_next;
            out_avg_reg   <= avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
            ptr_reg      <= '0;
            sum_reg      <= '0;
            mode_reg     <= MODE_IDLE;
            low_thr_reg  <= THRESH_W'(2048);
            high_thr_reg <= THRESH_W'(10240);
        end
        else
        begin
            if (cmd.update)
            begin
                ring_reg[ptr_reg] <= root_reg;
                sum_reg           <= sum_next;
                ptr_reg           <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                mode_reg <= mode_next;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
                    REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    assign detector_state    = out_state_reg;
    assign average_magnitude = out_avg_reg;

endmodule

// File: rtl/fall_detect_magnitude_average.sv
// Fall detector top level: joins the controller and the datapath to the
// request channels and the threshold write port. Uses fdma_pkg and both interfaces.
//
// Each accepted sample yields one result: the detector state after the sample
// and the moving average of the last 16 acceleration magnitudes. The three axes
// are squared in turn on the single 16x16 squarer and summed, the root is
// started, sixteen one-bit steps form the square root, the magnitude window is
// updated and the state rules are applied, waiting while the result register is
// still full. A new sample is accepted the cycle after the result is loaded, and
// not while one is being worked on; the result register holds one finished
// result while the next sample is being worked on.
module fall_detect_magnitude_average (
    input  logic                                 clk,
    input  logic                                 rst_n,
    fdma_sample_if.sink                          sample,
    fdma_result_if.source                        result,
    input  logic                                 cfg_write_en,
    input  logic [fdma_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fdma_pkg::THRESH_W-1:0]        cfg_data
);
    import fdma_pkg::*;

    fdma_cmd_t cmd;

    fdma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    fdma_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .accel_x           (sample.accel_x),
        .accel_y           (sample.accel_y),
        .accel_z           (sample.accel_z),
        .interval_elapsed  (sample.interval_elapsed),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .detector_state    (result.detector_state),
        .average_magnitude (result.average_magnitude)
    );

endmodule

// File: sim/tb_fall_detect_magnitude_average.sv
`timescale 1ns / 100ps
// Testbench for fall_detect_magnitude_average: a directed table followed by
// shaped random fall episodes, checked against a local model of the detector.
// Depends on fdma_pkg and the fdma_sample_if and fdma_result_if interfaces.
module tb_fall_detect_magnitude_average;
    import fdma_pkg::*;

    localparam logic [THRESH_W-1:0] RESET_LOW  = 16'd2048;
    localparam logic [THRESH_W-1:0] RESET_HIGH = 16'd10240;
    localparam int LONG_STALL   = 300;
    localparam int PHASE_ITEMS  = 90;
    localparam int PHASE_COUNT  = 6;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] x;
        logic signed [ACCEL_W-1:0] y;
        logic signed [ACCEL_W-1:0] z;
        logic                      el;
    } accel_sample_t;

    typedef struct packed {
        logic [STATE_W-1:0] det_state;
        logic [MAG_W-1:0]   avg_mag;
    } detector_out_t;

    typedef enum logic {ROW_SAMPLE, ROW_RETUNE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        accel_sample_t      smp;
        bit                 typed;
        detector_out_t      want;
        logic [THRESH_W-1:0] low;
        logic [THRESH_W-1:0] high;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [THRESH_W-1:0]    cfg_data;

    fdma_sample_if smp_if();
    fdma_result_if res_if();

    fall_detect_magnitude_average uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (smp_if),
        .result       (res_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    logic [MAG_W-1:0]    mag_ring [WINDOW_LEN];
    logic [PTR_W-1:0]    ring_ptr;
    logic [SUM_W-1:0]    mag_sum;
    logic [STATE_W-1:0]  det_mode;
    logic [THRESH_W-1:0] low_thr;
    logic [THRESH_W-1:0] high_thr;

    detector_out_t pending_results[$];
    stim_row_t     stim_table[$];

    int  items_sent;
    int  results_checked;
    int  mismatch_count;
    int  settings_used;
    bit  no_idle;
    bit  long_stall_req;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic detector_out_t advance_detector(accel_sample_t s);
        longint           sx;
        longint           sy;
        longint           sz;
        logic [63:0]      energy;
        logic [63:0]      root;
        logic [63:0]      cand;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] avg;
        detector_out_t    r;
        sx = s.x;
        sy = s.y;
        sz = s.z;
        energy = sx * sx + sy * sy + sz * sz;
        root = '0;
        for (int i = MAG_W - 1; i >= 0; i--)
        begin
            cand = root | (64'd1 << i);
            if (cand * cand <= energy)
                root = cand;
        end
        mag = root[MAG_W-1:0];
        mag_sum = mag_sum - SUM_W'(mag_ring[ring_ptr]) + SUM_W'(mag);
        mag_ring[ring_ptr] = mag;
        ring_ptr = ring_ptr + 1'b1;
        avg = MAG_W'(mag_sum >> WIN_LOG2);
        if (det_mode == MODE_IDLE && avg < low_thr)
            det_mode = MODE_PRE_FALL;
        if (det_mode == MODE_PRE_FALL)
        begin
            if (avg > high_thr)
                det_mode = MODE_FALL;
            else if (s.el)
                det_mode = MODE_IDLE;
        end
        if (det_mode == MODE_FALL && s.el)
            det_mode = MODE_IDLE;
        r.det_state = det_mode;
        r.avg_mag = avg;
        return r;
    endfunction

    function automatic logic signed [ACCEL_W-1:0] jitter(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[ACCEL_W-1:0];
    endfunction

    function automatic accel_sample_t body_sample(int center_z, int spread, bit elapsed);
        accel_sample_t s;
        s.x = jitter(0, spread);
        s.y = jitter(0, spread);
        s.z = jitter(center_z, spread);
        s.el = elapsed | ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    function automatic accel_sample_t raw_sample();
        accel_sample_t s;
        s.x = ACCEL_W'($urandom());
        s.y = ACCEL_W'($urandom());
        s.z = ACCEL_W'($urandom());
        s.el = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic add_sample_row(int x, int y, int z, bit el, bit typed,
                                  logic [STATE_W-1:0] st, logic [MAG_W-1:0] avg);
        stim_row_t row;
        row.kind = ROW_SAMPLE;
        row.smp.x = x[ACCEL_W-1:0];
        row.smp.y = y[ACCEL_W-1:0];
        row.smp.z = z[ACCEL_W-1:0];
        row.smp.el = el;
        row.typed = typed;
        row.want.det_state = st;
        row.want.avg_mag = avg;
        row.low = '0;
        row.high = '0;
        stim_table.push_back(row);
    endtask

    task automatic add_retune_row(logic [THRESH_W-1:0] low, logic [THRESH_W-1:0] high);
        stim_row_t row;
        row.kind = ROW_RETUNE;
        row.smp = '0;
        row.typed = 1'b0;
        row.want = '0;
        row.low = low;
        row.high = high;
        stim_table.push_back(row);
    endtask

    task automatic offer_sample(accel_sample_t s, bit typed, detector_out_t typed_out);
        detector_out_t predicted;
        @(negedge clk);
        smp_if.valid <= 1'b1;
        smp_if.accel_x <= s.x;
        smp_if.accel_y <= s.y;
        smp_if.accel_z <= s.z;
        smp_if.interval_elapsed <= s.el;
        @(posedge clk);
        while (smp_if.ready !== 1'b1)
            @(posedge clk);
        predicted = advance_detector(s);
        pending_results.push_back(typed ? typed_out : predicted);
        items_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(accel_sample_t s);
        offer_sample(s, 1'b0, '0);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [THRESH_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_LOW_THRESHOLD)
            low_thr = value;
        else
            high_thr = value;
    endtask

    task automatic retune(logic [THRESH_W-1:0] low, logic [THRESH_W-1:0] high);
        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        write_register(REG_LOW_THRESHOLD, low);
        write_register(REG_HIGH_THRESHOLD, high);
        settings_used++;
    endtask

    task automatic run_episode();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            repeat ($urandom_range(2, 8)) send_item(body_sample(4096, 400, 1'b0));
            repeat ($urandom_range(4, 20)) send_item(body_sample(0, 300, 1'b0));
            if (kind != 5)
                repeat ($urandom_range(1, 8)) send_item(body_sample(0, 32767, 1'b0));
            send_item(body_sample(4096, 400, 1'b1));
        end
        else if (kind <= 7)
        begin
            repeat ($urandom_range(1, 10)) send_item(raw_sample());
        end
        else
        begin
            repeat ($urandom_range(3, 12))
                send_item(body_sample(0, 300, $urandom_range(0, 3) == 0));
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : result_drain
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (!no_idle)
                    repeat ($urandom_range(0, 24)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        detector_out_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no pending request, expected none, actual state %0d avg %0d",
                         $time, res_if.detector_state, res_if.average_magnitude);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (res_if.detector_state !== want.det_state)
                begin
                    $display("%0t: detector_state mismatch, expected %0d, actual %0d",
                             $time, want.det_state, res_if.detector_state);
                    mismatch_count++;
                end
                if (res_if.average_magnitude !== want.avg_mag)
                begin
                    $display("%0t: average_magnitude mismatch, expected %0d, actual %0d",
                             $time, want.avg_mag, res_if.average_magnitude);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int phase_end;
        rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.accel_x = '0;
        smp_if.accel_y = '0;
        smp_if.accel_z = '0;
        smp_if.interval_elapsed = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        settings_used = 0;
        no_idle = 1'b0;
        long_stall_req = 1'b0;
        for (int i = 0; i < WINDOW_LEN; i++)
            mag_ring[i] = '0;
        ring_ptr = '0;
        mag_sum = '0;
        det_mode = MODE_IDLE;
        low_thr = RESET_LOW;
        high_thr = RESET_HIGH;

        // A window of zeros after reset gives a zero average, which is below the
        // default low threshold.
        add_sample_row(0, 0, 0, 1'b0, 1'b1, MODE_PRE_FALL, 16'd0);
        add_sample_row(0, 0, 0, 1'b1, 1'b1, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, 0, 1'b0, 1'b1, MODE_PRE_FALL, 16'd0);
        add_sample_row(-32768, -32768, -32768, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(-32768, -32768, -32768, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(-32768, -32768, -32768, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(32767, 32767, 32767, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(32767, -32768, 0, 1'b1, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, 4096, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(4096, 0, 0, 1'b1, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(-1, -1, -1, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(1, -1, 1, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, -32768, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(12345, -23456, 7890, 1'b1, 1'b0, MODE_IDLE, 16'd0);
        add_retune_row(16'd0, 16'hFFFF);
        add_sample_row(0, 0, 0, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, 0, 1'b1, 1'b0, MODE_IDLE, 16'd0);
        // With the low threshold above the high one, a single request can pass
        // through every state.
        add_retune_row(16'hFFFF, 16'd0);
        add_sample_row(0, 0, 4096, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, 4096, 1'b1, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(100, 100, 100, 1'b1, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(-32768, -32768, -32768, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_retune_row(RESET_LOW, RESET_HIGH);
        add_sample_row(0, 0, 0, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, 0, 1'b0, 1'b0, MODE_IDLE, 16'd0);
        add_sample_row(0, 0, 0, 1'b1, 1'b0, MODE_IDLE, 16'd0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_RETUNE)
                retune(stim_table[i].low, stim_table[i].high);
            else
                offer_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: retune(RESET_LOW, RESET_HIGH);
                1: retune(16'd0, 16'hFFFF);
                2: retune(16'hFFFF, 16'd0);
                3: retune(THRESH_W'($urandom_range(500, 6000)),
                          THRESH_W'($urandom_range(4000, 20000)));
                4: retune(THRESH_W'($urandom_range(0, 65535)),
                          THRESH_W'($urandom_range(0, 65535)));
                default:
                begin
                    no_idle = 1'b1;
                    retune(16'd4096, 16'd8192);
                end
            endcase
            if (p == 0)
                long_stall_req = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_episode();
        end

        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples across %0d threshold settings, with one long result stall.",
                 items_sent, settings_used);
        $display("Checked %0d results field by field; %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/fdma_pkg.sv
rtl/fdma_sample_if.sv
rtl/fdma_result_if.sv
rtl/fdma_ctrl.sv
rtl/fdma_datapath.sv
rtl/fall_detect_magnitude_average.sv
sim/tb_fall_detect_magnitude_average.sv
